// File: design/hdrf_pkg.sv
package hdrf_pkg;

  localparam int VERTEX_W   = 16;
  localparam int MAX_PARTS  = 32;
  localparam int PART_W     = 5;
  localparam int NPART_W    = 6;
  localparam int WORD_W     = 32;
  localparam int LAMBDA_W   = 24;
  localparam int DEN_W      = 49;
  localparam int DIVD_W     = 64;
  localparam int DIV_CNT_W  = 6;
  localparam int DIV_STEPS  = 64;
  localparam int RT_W       = 18;
  localparam int PROD_W     = LAMBDA_W + WORD_W;
  localparam int SCORE_W    = PROD_W + 2;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 3;

  localparam logic [WORD_W-1:0] ALL32    = '1;
  localparam logic [RT_W-1:0]   TWO_Q16  = RT_W'(131072);
  localparam logic [RT_W-1:0]   RT_HALF  = RT_W'(98304);
  localparam logic [DEN_W-1:0]  ONE_Q16  = DEN_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_PARTS  = 3'd1,
    CFG_CAP    = 3'd2,
    CFG_WEIGHT = 3'd3,
    CFG_EPS    = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DEN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] x);
    return (x == ALL32) ? x : x + WORD_W'(1);
  endfunction

endpackage

// File: design/hdrf_ram.sv
module hdrf_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/hdrf_div.sv
module hdrf_div (
  input  logic               clk,
  input  logic               rst,
  input  hdrf_pkg::div_req_t req,
  output hdrf_pkg::div_rsp_t rsp
);

  logic                           busy;
  logic                           done;
  logic [hdrf_pkg::DIV_CNT_W-1:0] cnt;
  logic [hdrf_pkg::DEN_W-1:0]     rem;
  logic [hdrf_pkg::DEN_W-1:0]     dvs;
  logic [hdrf_pkg::DIVD_W-1:0]    quo;
  logic [hdrf_pkg::DEN_W:0]       trial;
  logic                           qbit;
  logic [hdrf_pkg::DEN_W-1:0]     rem_next;

  // restoring divide, one quotient bit per cycle
  always_comb begin
    trial    = {rem, quo[hdrf_pkg::DIVD_W-1]};
    qbit     = trial >= {1'b0, dvs};
    rem_next = qbit ? hdrf_pkg::DEN_W'(trial - {1'b0, dvs}) : trial[hdrf_pkg::DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + hdrf_pkg::DIV_CNT_W'(1);
        if (cnt == hdrf_pkg::DIV_CNT_W'(hdrf_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[hdrf_pkg::DIVD_W-2:0], qbit};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

// File: design/hdrf_streaming_edge_partitioner.sv
// Reset: a clearing pass zeroes the degree and replica memories; no input is taken.
// Preload: degree written as accepted. Same-community edge in prepartition mode: no result.
// Placed edge: reads, degree write-back (not in prepartition mode), two ratio divides on the
// serial divider (none when the degree sum is zero), then scoring of each partition not full;
// in prepartition mode a nonzero balance with nonzero normalizer adds a balance divide.
// One edge in flight; the result register frees the sequencer.
module hdrf_streaming_edge_partitioner (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // vertex_a, vertex_b, degree_value, comm_part_a, comm_part_b, zero pad
  input  logic [hdrf_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // req_type
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // chosen_partition, load_after, zero pad
  output logic [hdrf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hdrf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hdrf_pkg::WORD_W-1:0]        cfg_data
);

  typedef enum logic [17:0] {
    S_CLEAR = 18'h00001,
    S_IDLE  = 18'h00002,
    S_RDA   = 18'h00004,
    S_RDB   = 18'h00008,
    S_CAPB  = 18'h00010,
    S_WRA   = 18'h00020,
    S_WRB   = 18'h00040,
    S_RAS   = 18'h00080,
    S_RAW   = 18'h00100,
    S_RBS   = 18'h00200,
    S_RBW   = 18'h00400,
    S_LOADP = 18'h00800,
    S_BW    = 18'h01000,
    S_MUL   = 18'h02000,
    S_ACC   = 18'h04000,
    S_UPDA  = 18'h08000,
    S_UPDB  = 18'h10000,
    S_OUT   = 18'h20000
  } state_t;

  state_t state;

  logic                               prep_mode;
  logic [hdrf_pkg::NPART_W-1:0]       parts_in_use;
  logic [hdrf_pkg::WORD_W-1:0]        load_cap;
  logic [hdrf_pkg::LAMBDA_W-1:0]      weight;
  logic [hdrf_pkg::WORD_W-1:0]        epsilon;

  logic [hdrf_pkg::WORD_W-1:0]        load [hdrf_pkg::MAX_PARTS];
  logic [hdrf_pkg::WORD_W-1:0]        hl;

  logic [hdrf_pkg::VERTEX_W-1:0]      clr_addr;
  logic [hdrf_pkg::VERTEX_W-1:0]      va;
  logic [hdrf_pkg::VERTEX_W-1:0]      vb;
  logic [hdrf_pkg::WORD_W-1:0]        du;
  logic [hdrf_pkg::WORD_W-1:0]        dv;
  logic [hdrf_pkg::MAX_PARTS-1:0]     ba;
  logic [hdrf_pkg::MAX_PARTS-1:0]     bb;
  logic [hdrf_pkg::DEN_W-1:0]         den;
  logic [hdrf_pkg::RT_W-1:0]          rt_a;
  logic [hdrf_pkg::RT_W-1:0]          rt_b;
  logic [hdrf_pkg::NPART_W-1:0]       p;
  logic [hdrf_pkg::PART_W-1:0]        best_p;
  logic [hdrf_pkg::SCORE_W-1:0]       best;
  logic [hdrf_pkg::WORD_W-1:0]        bal_x;
  logic [hdrf_pkg::PROD_W-1:0]        prod;
  logic [hdrf_pkg::WORD_W-1:0]        ld_after;
  logic                               m_valid;
  logic [hdrf_pkg::OUT_DATA_W-1:0]    m_data;

  logic                               accept;
  logic                               in_req;
  logic [hdrf_pkg::VERTEX_W-1:0]      in_va;
  logic [hdrf_pkg::VERTEX_W-1:0]      in_vb;
  logic [hdrf_pkg::WORD_W-1:0]        in_deg;
  logic [hdrf_pkg::PART_W-1:0]        in_ca;
  logic [hdrf_pkg::PART_W-1:0]        in_cb;

  logic                               deg_we;
  logic [hdrf_pkg::VERTEX_W-1:0]      deg_waddr;
  logic [hdrf_pkg::WORD_W-1:0]        deg_wdata;
  logic [hdrf_pkg::WORD_W-1:0]        deg_rd;
  logic                               bmp_we;
  logic [hdrf_pkg::VERTEX_W-1:0]      bmp_waddr;
  logic [hdrf_pkg::MAX_PARTS-1:0]     bmp_wdata;
  logic [hdrf_pkg::MAX_PARTS-1:0]     bmp_rd;
  logic [hdrf_pkg::VERTEX_W-1:0]      raddr;
  logic [hdrf_pkg::MAX_PARTS-1:0]     best_mask;

  logic [hdrf_pkg::NPART_W-1:0]       nparts;
  logic [hdrf_pkg::WORD_W:0]          sum;
  logic [hdrf_pkg::PART_W-1:0]        ld_idx;
  logic [hdrf_pkg::WORD_W-1:0]        ld_rd;
  logic [hdrf_pkg::WORD_W-1:0]        ld_inc;
  logic [hdrf_pkg::WORD_W-1:0]        bal;
  logic                               p_done;
  logic                               p_full;
  logic                               launch_bal;
  logic [hdrf_pkg::DEN_W-1:0]         den_full;
  logic [hdrf_pkg::DEN_W-1:0]         den_calc;
  logic [hdrf_pkg::WORD_W-1:0]        da_inc;
  logic [hdrf_pkg::WORD_W-1:0]        da_inc2;
  logic [hdrf_pkg::SCORE_W-1:0]       term;
  logic [hdrf_pkg::SCORE_W-1:0]       score;
  logic                               out_load;

  hdrf_pkg::div_req_t                 div_req;
  hdrf_pkg::div_rsp_t                 div_rsp;

  assign in_req = s_axis_tuser[0];
  assign in_va  = s_axis_tdata[15:0];
  assign in_vb  = s_axis_tdata[31:16];
  assign in_deg = s_axis_tdata[63:32];
  assign in_ca  = s_axis_tdata[68:64];
  assign in_cb  = s_axis_tdata[73:69];

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid & s_axis_tready;
  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;

  assign nparts = (parts_in_use > hdrf_pkg::NPART_W'(hdrf_pkg::MAX_PARTS))
                  ? hdrf_pkg::NPART_W'(hdrf_pkg::MAX_PARTS) : parts_in_use;
  assign sum    = {1'b0, du} + {1'b0, dv};
  assign ld_idx = (state == S_UPDA) ? best_p : p[hdrf_pkg::PART_W-1:0];
  assign ld_rd  = load[ld_idx];
  assign ld_inc = hdrf_pkg::sat_inc(ld_rd);
  assign bal    = hl - ld_rd;
  assign p_done = p >= nparts;
  assign p_full = prep_mode && (ld_rd >= load_cap);
  assign launch_bal = (state == S_LOADP) && !p_done && !p_full && prep_mode
                      && (bal != '0) && (den != '0);
  assign best_mask = hdrf_pkg::MAX_PARTS'(1) << best_p;
  assign da_inc  = hdrf_pkg::sat_inc(du);
  assign da_inc2 = hdrf_pkg::sat_inc(da_inc);
  assign raddr   = (state == S_RDB) ? vb : va;

  // balance normalizer: epsilon + (highest_load - 1) in Q16.16, floored at zero
  assign den_full = hdrf_pkg::DEN_W'(epsilon) + {1'b0, hl, 16'h0000};
  assign den_calc = (den_full < hdrf_pkg::ONE_Q16) ? '0 : den_full - hdrf_pkg::ONE_Q16;

  assign term  = prep_mode ? hdrf_pkg::SCORE_W'(prod >> 16) : hdrf_pkg::SCORE_W'(prod);
  assign score = term
               + (ba[p[hdrf_pkg::PART_W-1:0]] ? hdrf_pkg::SCORE_W'(rt_a) : '0)
               + (bb[p[hdrf_pkg::PART_W-1:0]] ? hdrf_pkg::SCORE_W'(rt_b) : '0);

  assign out_load = (state == S_OUT) && (!m_valid || m_axis_tready);

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {16'h0000, du, 16'h0000};
    div_req.divisor  = hdrf_pkg::DEN_W'(sum);
    case (state)
      S_RAS: begin
        div_req.start = (sum != '0);
      end
      S_RBS: begin
        div_req.start    = 1'b1;
        div_req.dividend = {16'h0000, dv, 16'h0000};
      end
      S_LOADP: begin
        div_req.start    = launch_bal;
        div_req.dividend = {bal, 32'h0000_0000};
        div_req.divisor  = den;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    deg_we    = 1'b0;
    deg_waddr = va;
    deg_wdata = du;
    bmp_we    = 1'b0;
    bmp_waddr = va;
    bmp_wdata = ba | best_mask;
    case (state)
      S_CLEAR: begin
        deg_we    = 1'b1;
        deg_waddr = clr_addr;
        deg_wdata = '0;
        bmp_we    = 1'b1;
        bmp_waddr = clr_addr;
        bmp_wdata = '0;
      end
      S_IDLE: begin
        deg_we    = accept & in_req;
        deg_waddr = in_va;
        deg_wdata = in_deg;
      end
      S_WRA: begin
        deg_we = 1'b1;
      end
      S_WRB: begin
        deg_we    = 1'b1;
        deg_waddr = vb;
        deg_wdata = dv;
      end
      S_UPDA: begin
        bmp_we = 1'b1;
      end
      S_UPDB: begin
        bmp_we    = 1'b1;
        bmp_waddr = vb;
        bmp_wdata = bb | best_mask;
      end
      default: begin
      end
    endcase
  end

  hdrf_ram #(.ADDR_W(hdrf_pkg::VERTEX_W), .DATA_W(hdrf_pkg::WORD_W)) u_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr),
    .wdata (deg_wdata),
    .raddr (raddr),
    .rdata (deg_rd)
  );

  hdrf_ram #(.ADDR_W(hdrf_pkg::VERTEX_W), .DATA_W(hdrf_pkg::MAX_PARTS)) u_bmp_ram (
    .clk   (clk),
    .we    (bmp_we),
    .waddr (bmp_waddr),
    .wdata (bmp_wdata),
    .raddr (raddr),
    .rdata (bmp_rd)
  );

  hdrf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_mode    <= 1'b0;
      parts_in_use <= hdrf_pkg::NPART_W'(hdrf_pkg::MAX_PARTS);
      load_cap     <= hdrf_pkg::ALL32;
      weight       <= hdrf_pkg::LAMBDA_W'(65536);
      epsilon      <= hdrf_pkg::WORD_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hdrf_pkg::CFG_MODE:   prep_mode    <= cfg_data[0];
        hdrf_pkg::CFG_PARTS:  parts_in_use <= cfg_data[hdrf_pkg::NPART_W-1:0];
        hdrf_pkg::CFG_CAP:    load_cap     <= cfg_data;
        hdrf_pkg::CFG_WEIGHT: weight       <= cfg_data[hdrf_pkg::LAMBDA_W-1:0];
        hdrf_pkg::CFG_EPS:    epsilon      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      hl       <= '0;
      m_valid  <= 1'b0;
      for (int i = 0; i < hdrf_pkg::MAX_PARTS; i++) begin
        load[i] <= '0;
      end
    end else begin
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + hdrf_pkg::VERTEX_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept && !in_req && !(prep_mode && in_ca == in_cb)) begin
            state <= S_RDA;
          end
        end
        S_RDA:  state <= S_RDB;
        S_RDB:  state <= S_CAPB;
        S_CAPB: state <= prep_mode ? S_RAS : S_WRA;
        S_WRA:  state <= S_WRB;
        S_WRB:  state <= S_RAS;
        S_RAS:  state <= (sum == '0) ? S_LOADP : S_RAW;
        S_RAW: begin
          if (div_rsp.done) begin
            state <= S_RBS;
          end
        end
        S_RBS:  state <= S_RBW;
        S_RBW: begin
          if (div_rsp.done) begin
            state <= S_LOADP;
          end
        end
        S_LOADP: begin
          if (p_done) begin
            state <= S_UPDA;
          end else if (!p_full) begin
            state <= launch_bal ? S_BW : S_MUL;
          end
        end
        S_BW: begin
          if (div_rsp.done) begin
            state <= S_MUL;
          end
        end
        S_MUL:  state <= S_ACC;
        S_ACC:  state <= S_LOADP;
        S_UPDA: begin
          load[best_p] <= ld_inc;
          if (ld_inc > hl) begin
            hl <= ld_inc;
          end
          state <= S_UPDB;
        end
        S_UPDB: state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        va <= in_va;
        vb <= in_vb;
      end
      S_RDB: begin
        du <= deg_rd;
        ba <= bmp_rd;
      end
      S_CAPB: begin
        bb     <= bmp_rd;
        den    <= den_calc;
        p      <= '0;
        best   <= '0;
        best_p <= '0;
        if (!prep_mode) begin
          // same vertex on both ends counts twice
          if (va == vb) begin
            du <= da_inc2;
            dv <= da_inc2;
          end else begin
            du <= da_inc;
            dv <= hdrf_pkg::sat_inc(deg_rd);
          end
        end else begin
          dv <= deg_rd;
        end
      end
      S_RAS: begin
        rt_a <= hdrf_pkg::RT_HALF;
        rt_b <= hdrf_pkg::RT_HALF;
      end
      S_RAW: begin
        rt_a <= hdrf_pkg::TWO_Q16 - hdrf_pkg::RT_W'(div_rsp.quotient);
      end
      S_RBW: begin
        rt_b <= hdrf_pkg::TWO_Q16 - hdrf_pkg::RT_W'(div_rsp.quotient);
      end
      S_LOADP: begin
        if (!p_done && p_full) begin
          p <= p + hdrf_pkg::NPART_W'(1);
        end
        if (!prep_mode || bal == '0) begin
          bal_x <= bal;
        end else begin
          bal_x <= hdrf_pkg::ALL32;
        end
      end
      S_BW: begin
        bal_x <= (div_rsp.quotient[63:32] != '0) ? hdrf_pkg::ALL32 : div_rsp.quotient[31:0];
      end
      S_MUL: begin
        prod <= hdrf_pkg::PROD_W'(weight) * hdrf_pkg::PROD_W'(bal_x);
      end
      S_ACC: begin
        if (score > best) begin
          best   <= score;
          best_p <= p[hdrf_pkg::PART_W-1:0];
        end
        p <= p + hdrf_pkg::NPART_W'(1);
      end
      S_UPDA: begin
        ld_after <= ld_inc;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      m_data <= {3'b000, ld_after, best_p};
    end
  end

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_best_range: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT |-> (best_p == '0 || {1'b0, best_p} < nparts))
    else $error("chosen partition outside scored range");

  a_hl_max: assert property (@(posedge clk) disable iff (rst)
    state == S_UPDB |-> hl >= load[best_p])
    else $error("highest load below updated partition load");

  a_div_result: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_RAW || state == S_RBW || state == S_BW))
    else $error("divider result with no waiting state");

endmodule

// File: tb/sv/hdrf_partition_checker.sv
`timescale 1ns / 100ps

module hdrf_partition_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [hdrf_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic [0:0]                      s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [hdrf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [hdrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hdrf_pkg::WORD_W-1:0]     cfg_data,
  output int                              pending,
  output int                              fail_count
);

  typedef struct packed {
    logic [4:0]  part;
    logic [31:0] load;
  } placement_t;

  logic [31:0] deg_mem [0:65535];
  logic [31:0] rep_mem [0:65535];
  logic [31:0] load_mem [0:31];
  logic [31:0] top_load;

  logic        mode_r;
  logic [5:0]  parts_r;
  logic [31:0] cap_r;
  logic [23:0] lambda_r;
  logic [31:0] eps_r;

  placement_t placements_due[$];

  function automatic logic [31:0] inc_sat(input logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  function automatic logic [63:0] rep_score(input logic [31:0] d, input logic [63:0] s);
    logic [63:0] ratio;
    ratio = (s == 0) ? 64'd32768 : ({32'd0, d} << 16) / s;
    return 64'd131072 - ratio;
  endfunction

  function automatic logic [63:0] bal_score(input logic [31:0] bal);
    logic [63:0] den, q;
    if (!mode_r) return {40'd0, lambda_r} * {32'd0, bal};
    den = {32'd0, eps_r} + ({32'd0, top_load} << 16);
    den = (den < 64'd65536) ? 64'd0 : den - 64'd65536;
    if (bal == 0) return 64'd0;
    if (den == 0) q = 64'hFFFF_FFFF;
    else begin
      q = ({32'd0, bal} << 32) / den;
      if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    end
    return ({40'd0, lambda_r} * q) >> 16;
  endfunction

  // returns 1 when the edge is placed
  function automatic bit place_edge(input logic req,
                                    input logic [hdrf_pkg::IN_DATA_W-1:0] d,
                                    output placement_t res);
    logic [15:0] va, vb;
    logic [31:0] du, dv;
    logic [63:0] s, sc, best;
    int n, bp;
    va = d[15:0];
    vb = d[31:16];
    res = '0;
    if (req) begin
      deg_mem[va] = d[63:32];
      return 0;
    end
    if (mode_r) begin
      if (d[68:64] == d[73:69]) return 0;
    end else begin
      deg_mem[va] = inc_sat(deg_mem[va]);
      deg_mem[vb] = inc_sat(deg_mem[vb]);
    end
    du = deg_mem[va];
    dv = deg_mem[vb];
    s = {32'd0, du} + {32'd0, dv};
    n = (parts_r > 32) ? 32 : parts_r;
    best = 0;
    bp = 0;
    for (int p = 0; p < n; p++) begin
      if (mode_r && load_mem[p] >= cap_r) continue;
      sc = bal_score(top_load - load_mem[p]);
      if (rep_mem[va][p]) sc += rep_score(du, s);
      if (rep_mem[vb][p]) sc += rep_score(dv, s);
      if (sc > best) begin
        best = sc;
        bp = p;
      end
    end
    rep_mem[va][bp] = 1'b1;
    rep_mem[vb][bp] = 1'b1;
    load_mem[bp] = inc_sat(load_mem[bp]);
    if (load_mem[bp] > top_load) top_load = load_mem[bp];
    res.part = bp[4:0];
    res.load = load_mem[bp];
    return 1;
  endfunction

  assign pending = placements_due.size();

  initial begin
    for (int i = 0; i < 65536; i++) begin
      deg_mem[i] = '0;
      rep_mem[i] = '0;
    end
    for (int i = 0; i < 32; i++) load_mem[i] = '0;
    top_load = '0;
    mode_r = 1'b0;
    parts_r = 6'd32;
    cap_r = 32'hFFFF_FFFF;
    lambda_r = 24'd65536;
    eps_r = 32'd65536;
    fail_count = 0;
  end

  always @(posedge clk) begin
    placement_t r, got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (hdrf_pkg::cfg_idx_t'(cfg_index))
          hdrf_pkg::CFG_MODE:   mode_r <= cfg_data[0];
          hdrf_pkg::CFG_PARTS:  parts_r <= cfg_data[5:0];
          hdrf_pkg::CFG_CAP:    cap_r <= cfg_data;
          hdrf_pkg::CFG_WEIGHT: lambda_r <= cfg_data[23:0];
          hdrf_pkg::CFG_EPS:    eps_r <= cfg_data;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (place_edge(s_axis_tuser[0], s_axis_tdata, r)) placements_due.push_back(r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.part = m_axis_tdata[4:0];
        got.load = m_axis_tdata[36:5];
        if (placements_due.size() == 0) begin
          $error("unexpected result transaction: chosen_partition %0d load_after %0d",
                 got.part, got.load);
          fail_count++;
        end else begin
          r = placements_due.pop_front();
          if (got.part !== r.part) begin
            $error("chosen_partition: expected %0d, actual %0d", r.part, got.part);
            fail_count++;
          end
          if (got.load !== r.load) begin
            $error("load_after: expected %0d, actual %0d", r.load, got.load);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int STALL_LIMIT = 200000;

  logic                            clk;
  logic                            rst;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [hdrf_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic [0:0]                      s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [hdrf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [hdrf_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [hdrf_pkg::WORD_W-1:0]     cfg_data;
  int                              pending;
  int                              fail_count;
  int                              quiet_cycles;
  bit                              calm;

  hdrf_streaming_edge_partitioner DUT (.*);

  hdrf_partition_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // receiver back-pressure
  int sink_hold;
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      sink_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  task automatic send_req(input logic req, input logic [15:0] va, input logic [15:0] vb,
                          input logic [31:0] dg, input logic [4:0] ca, input logic [4:0] cb);
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {6'd0, cb, ca, dg, vb, va};
    forever begin
      @(negedge clk);
      if (s_axis_tready) break;
    end
    @(posedge clk);
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_reg(input hdrf_pkg::cfg_idx_t idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_vertex();
    return ($urandom_range(9) < 8) ? 16'($urandom_range(40)) : 16'($urandom);
  endfunction

  task automatic random_reqs(input int count, input int preload_pct);
    logic [4:0] ca, cb;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(199) == 0) calm = ~calm;
      ca = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
      cb = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
      if ($urandom_range(99) < preload_pct)
        send_req(1'b1, pick_vertex(), 16'($urandom),
                 ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(50)),
                 ca, cb);
      else
        send_req(1'b0, pick_vertex(), pick_vertex(), 32'($urandom), ca, cb);
    end
    calm = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    calm = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: plain mode with reset settings
    send_req(1'b0, 16'd0, 16'd65535, 32'd0, 5'd0, 5'd31);
    send_req(1'b0, 16'd0, 16'd0, 32'hFFFF_FFFF, 5'd31, 5'd0);
    send_req(1'b0, 16'd65535, 16'd1, 32'd0, 5'd3, 5'd3);
    send_req(1'b1, 16'd7, 16'd0, 32'hFFFF_FFFF, 5'd0, 5'd0);
    send_req(1'b0, 16'd7, 16'd8, 32'd0, 5'd0, 5'd0);   // degree saturates
    send_req(1'b0, 16'd7, 16'd7, 32'd0, 5'd0, 5'd0);
    send_req(1'b1, 16'd65535, 16'hFFFF, 32'd0, 5'd31, 5'd31);
    send_req(1'b0, 16'd1, 16'd65535, 32'd0, 5'd0, 5'd1);
    random_reqs(300, 10);
    drain();

    write_reg(hdrf_pkg::CFG_PARTS, 32'd1);
    write_reg(hdrf_pkg::CFG_WEIGHT, 32'd0);
    random_reqs(60, 10);
    drain();

    // out-of-range partition counts
    write_reg(hdrf_pkg::CFG_PARTS, 32'd0);
    random_reqs(10, 10);
    drain();
    write_reg(hdrf_pkg::CFG_PARTS, 32'd63);
    write_reg(hdrf_pkg::CFG_WEIGHT, 32'hFF_FFFF);
    random_reqs(10, 10);
    drain();

    // prepartition: preload degrees, zero degree sum, zero epsilon, small cap
    write_reg(hdrf_pkg::CFG_MODE, 32'd1);
    write_reg(hdrf_pkg::CFG_PARTS, 32'd8);
    write_reg(hdrf_pkg::CFG_CAP, 32'd5);
    write_reg(hdrf_pkg::CFG_EPS, 32'd0);
    send_req(1'b0, 16'd100, 16'd101, 32'd0, 5'd2, 5'd2);  // same community, skipped
    send_req(1'b0, 16'd100, 16'd101, 32'd0, 5'd2, 5'd5);  // zero degree sum
    send_req(1'b1, 16'd100, 16'd0, 32'd3, 5'd0, 5'd0);
    send_req(1'b0, 16'd100, 16'd101, 32'd0, 5'd0, 5'd31);
    send_req(1'b0, 16'd100, 16'd102, 32'd0, 5'd31, 5'd30);
    random_reqs(250, 30);
    drain();

    write_reg(hdrf_pkg::CFG_PARTS, 32'd32);
    write_reg(hdrf_pkg::CFG_CAP, 32'hFFFF_FFFF);
    write_reg(hdrf_pkg::CFG_EPS, 32'hFFFF_FFFF);
    write_reg(hdrf_pkg::CFG_WEIGHT, 32'd65536);
    random_reqs(100, 30);
    drain();

    // every partition full
    write_reg(hdrf_pkg::CFG_CAP, 32'd0);
    write_reg(hdrf_pkg::CFG_PARTS, 32'd4);
    random_reqs(20, 30);
    drain();

    write_reg(hdrf_pkg::CFG_MODE, 32'd0);
    for (int k = 0; k < 4; k++) begin
      write_reg(hdrf_pkg::CFG_PARTS, $urandom_range(32, 1));
      write_reg(hdrf_pkg::CFG_WEIGHT,
                ($urandom_range(1) == 0) ? $urandom_range(131072) : $urandom);
      write_reg(hdrf_pkg::CFG_EPS, $urandom);
      write_reg(hdrf_pkg::CFG_CAP, $urandom);
      random_reqs(120, 10);
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

// File: sim.f
design/hdrf_pkg.sv
design/hdrf_ram.sv
design/hdrf_div.sv
design/hdrf_streaming_edge_partitioner.sv
tb/sv/hdrf_partition_checker.sv
tb/sv/testbench.sv
